### design/tcce_pkg.sv
package tcce_pkg;

    // Command codes carried in the command field
    typedef enum logic [2:0] {
        CMD_PUT_CHAR   = 3'd0,
        CMD_SET_CURSOR = 3'd1,
        CMD_LEFT       = 3'd2,
        CMD_RIGHT      = 3'd3,
        CMD_HOME       = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_BLINK_TICK = 3'd6,
        CMD_READ_CELL  = 3'd7
    } tcce_cmd_t;

    // Control characters and fill values
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_BLINK   = 2'd2;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;
    localparam logic [7:0] BLINK_RESET   = 8'd50;

    localparam int CFG_ADDR_W = 4;
    localparam int CELL_W     = 16;

    typedef struct packed {
        tcce_cmd_t   command;
        logic [7:0]  character;
        logic [7:0]  attribute;
        logic [6:0]  target_row;
        logic [6:0]  target_column;
    } tcce_in_t;

    typedef struct packed {
        logic [6:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic        cursor_shown;
        logic        scrolled;
        logic        cell_changed;
        logic [6:0]  cell_row;
        logic [6:0]  cell_column;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attribute;
    } tcce_out_t;

    typedef struct packed {
        logic [7:0]  columns_in_use;
        logic [6:0]  rows_in_use;
        logic [7:0]  blink_period;
    } tcce_cfg_t;

endpackage

### design/tcce_ram.sv
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12288
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/tcce_cfg.sv
module tcce_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcce_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output tcce_pkg::tcce_cfg_t                cfg
);

    tcce_pkg::tcce_cfg_t cfg_reg;
    logic                wr_hit;
    logic [1:0]          reg_sel;

    assign reg_sel = paddr[3:2];
    assign wr_hit  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Take register writes in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns_in_use <= tcce_pkg::COLUMNS_RESET;
            cfg_reg.rows_in_use    <= tcce_pkg::ROWS_RESET;
            cfg_reg.blink_period   <= tcce_pkg::BLINK_RESET;
        end
        else if (wr_hit)
        begin
            unique case (reg_sel)
                tcce_pkg::REG_COLUMNS:
                begin
                    cfg_reg.columns_in_use <= pwdata[7:0];
                end
                tcce_pkg::REG_ROWS:
                begin
                    cfg_reg.rows_in_use <= pwdata[6:0];
                end
                tcce_pkg::REG_BLINK:
                begin
                    cfg_reg.blink_period <= pwdata[7:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Return the addressed register, zero elsewhere
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            tcce_pkg::REG_COLUMNS:
            begin
                prdata[7:0] = cfg_reg.columns_in_use;
            end
            tcce_pkg::REG_ROWS:
            begin
                prdata[6:0] = cfg_reg.rows_in_use;
            end
            tcce_pkg::REG_BLINK:
            begin
                prdata[7:0] = cfg_reg.blink_period;
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

endmodule

### design/tcce_ctrl.sv
module tcce_ctrl #(
    parameter int MAX_ROWS    = 96,
    parameter int MAX_COLUMNS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tcce_pkg::tcce_in_t   request,
    input  tcce_pkg::tcce_cfg_t  cfg,
    output logic                 busy,
    output logic                 done,
    output tcce_pkg::tcce_out_t  result
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);
    localparam int RAM_AW = $clog2(DEPTH);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY,
        S_BLANK
    } state_t;

    function automatic logic [RAM_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [ROW_W+COL_W-1:0] full;
        full = {r, c};
        return full[RAM_AW-1:0];
    endfunction

    state_t               state_reg, state_next;
    tcce_pkg::tcce_in_t   cmd_reg, cmd_next;
    logic [6:0]           cur_row_reg, cur_row_next;
    logic [6:0]           cur_col_reg, cur_col_next;
    logic                 vis_reg, vis_next;
    logic [7:0]           blink_reg, blink_next;
    logic [ROW_W-1:0]     sy_reg, sy_next;
    logic [COL_W-1:0]     sx_reg, sx_next;
    logic [ROW_W-1:0]     last_row_reg, last_row_next;
    logic [COL_W-1:0]     last_col_reg, last_col_next;
    logic [7:0]           fill_attr_reg, fill_attr_next;
    logic                 copy_pend_reg, copy_pend_next;
    logic [RAM_AW-1:0]    pend_addr_reg, pend_addr_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic                 done_reg, done_next;
    tcce_pkg::tcce_out_t  result_reg, result_next;

    logic                 wr_en, rd_en;
    logic [RAM_AW-1:0]    wr_addr, rd_addr;
    logic [15:0]          wr_data, rd_data;

    // Effective visible area and saturated cursor
    logic [7:0] nc, nr, period;
    logic [6:0] ncm1, nrm1, crow, ccol;
    logic [7:0] row_inc, col_inc;
    logic [8:0] blink_inc;
    logic       rd_in_range;

    assign nc = (cfg.columns_in_use == 8'd0) ? 8'd1 :
                (cfg.columns_in_use > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) :
                cfg.columns_in_use;
    assign nr = (cfg.rows_in_use == 7'd0) ? 8'd1 :
                ({1'b0, cfg.rows_in_use} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) :
                {1'b0, cfg.rows_in_use};
    assign period = (cfg.blink_period == 8'd0) ? 8'd1 : cfg.blink_period;
    assign ncm1 = 7'(nc - 8'd1);
    assign nrm1 = 7'(nr - 8'd1);
    assign crow = ({1'b0, cur_row_reg} >= nr) ? nrm1 : cur_row_reg;
    assign ccol = ({1'b0, cur_col_reg} >= nc) ? ncm1 : cur_col_reg;
    assign row_inc = {1'b0, crow} + 8'd1;
    assign col_inc = {1'b0, ccol} + 8'd1;
    assign blink_inc = {1'b0, blink_reg} + 9'd1;
    assign rd_in_range = ({1'b0, cmd_reg.target_row} < 8'(MAX_ROWS)) &&
                         ({1'b0, cmd_reg.target_column} < 8'(MAX_COLUMNS));

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequence commands and sweeps over the cell store
    always_comb
    begin
        logic [6:0] nrow, ncol, cr, cc;
        logic [7:0] cch, cat;
        logic       nvis, sc, chg;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        vis_next       = vis_reg;
        blink_next     = blink_reg;
        sy_next        = sy_reg;
        sx_next        = sx_reg;
        last_row_next  = last_row_reg;
        last_col_next  = last_col_reg;
        fill_attr_next = fill_attr_reg;
        copy_pend_next = 1'b0;
        pend_addr_next = pend_addr_reg;
        rd_ok_next     = rd_ok_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        nrow = crow;
        ncol = ccol;
        cr   = '0;
        cc   = '0;
        cch  = '0;
        cat  = '0;
        nvis = vis_reg;
        sc   = 1'b0;
        chg  = 1'b0;

        unique case (state_reg)
            S_FILL:
            begin
                // Blank every entry, row by row
                wr_en   = 1'b1;
                wr_addr = cell_addr(sy_reg, sx_reg);
                wr_data = {fill_attr_reg, tcce_pkg::CH_BLANK};
                sx_next = sx_reg + COL_W'(1);
                if (sx_reg == '1)
                begin
                    if (sy_reg == ROW_LAST)
                    begin
                        sy_next    = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sy_next = sy_reg + ROW_W'(1);
                    end
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = request;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (cmd_reg.command)
                    tcce_pkg::CMD_PUT_CHAR:
                    begin
                        nvis = 1'b1;
                        priority if (cmd_reg.character == tcce_pkg::CH_NEWLINE)
                        begin
                            ncol = '0;
                            if (row_inc >= nr)
                            begin
                                sc   = 1'b1;
                                nrow = nrm1;
                            end
                            else
                            begin
                                nrow = row_inc[6:0];
                            end
                        end
                        else if (cmd_reg.character == tcce_pkg::CH_RETURN)
                        begin
                            ncol = '0;
                        end
                        else if (cmd_reg.character == tcce_pkg::CH_BACKSPACE)
                        begin
                            if (ccol != '0)
                            begin
                                ncol = ccol - 7'd1;
                                chg  = 1'b1;
                            end
                            else if (crow != '0)
                            begin
                                nrow = crow - 7'd1;
                                ncol = ncm1;
                                chg  = 1'b1;
                            end
                            cr  = chg ? nrow : '0;
                            cc  = chg ? ncol : '0;
                            cch = chg ? tcce_pkg::CH_BLANK : '0;
                            cat = chg ? cmd_reg.attribute : '0;
                        end
                        else
                        begin
                            chg  = 1'b1;
                            cr   = crow;
                            cc   = ccol;
                            cch  = cmd_reg.character;
                            cat  = cmd_reg.attribute;
                            ncol = col_inc[6:0];
                            if (col_inc >= nc)
                            begin
                                ncol = '0;
                                if (row_inc >= nr)
                                begin
                                    sc   = 1'b1;
                                    nrow = nrm1;
                                end
                                else
                                begin
                                    nrow = row_inc[6:0];
                                end
                            end
                        end
                    end

                    tcce_pkg::CMD_SET_CURSOR:
                    begin
                        nrow = ({1'b0, cmd_reg.target_row} >= nr) ? nrm1 :
                               cmd_reg.target_row;
                        ncol = ({1'b0, cmd_reg.target_column} >= nc) ? ncm1 :
                               cmd_reg.target_column;
                        nvis = 1'b1;
                    end

                    tcce_pkg::CMD_LEFT:
                    begin
                        if (ccol != '0)
                        begin
                            ncol = ccol - 7'd1;
                        end
                        else if (crow != '0)
                        begin
                            nrow = crow - 7'd1;
                            ncol = ncm1;
                        end
                    end

                    tcce_pkg::CMD_RIGHT:
                    begin
                        if (col_inc < nc)
                        begin
                            ncol = col_inc[6:0];
                        end
                        else if (row_inc < nr)
                        begin
                            nrow = row_inc[6:0];
                            ncol = '0;
                        end
                    end

                    tcce_pkg::CMD_HOME:
                    begin
                        ncol = '0;
                    end

                    tcce_pkg::CMD_CLEAR:
                    begin
                        nrow           = '0;
                        ncol           = '0;
                        nvis           = 1'b1;
                        blink_next     = '0;
                        fill_attr_next = cmd_reg.attribute;
                        sy_next        = '0;
                        sx_next        = '0;
                        state_next     = S_FILL;
                    end

                    tcce_pkg::CMD_BLINK_TICK:
                    begin
                        if (blink_inc >= {1'b0, period})
                        begin
                            blink_next = '0;
                            nvis       = ~vis_reg;
                        end
                        else
                        begin
                            blink_next = blink_inc[7:0];
                        end
                    end

                    tcce_pkg::CMD_READ_CELL:
                    begin
                        rd_en      = rd_in_range;
                        rd_addr    = cell_addr(cmd_reg.target_row[ROW_W-1:0],
                                               cmd_reg.target_column[COL_W-1:0]);
                        rd_ok_next = rd_in_range;
                        state_next = S_READ;
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase

                cur_row_next = nrow;
                cur_col_next = ncol;
                vis_next     = nvis;

                // Write the one cell this command touches
                wr_en   = chg;
                wr_addr = cell_addr(cr[ROW_W-1:0], cc[COL_W-1:0]);
                wr_data = {cat, cch};

                // Launch the scroll: copy rows up, then blank the bottom row
                if (sc)
                begin
                    fill_attr_next = cmd_reg.attribute;
                    last_row_next  = nrm1[ROW_W-1:0];
                    last_col_next  = ncm1[COL_W-1:0];
                    sx_next        = '0;
                    sy_next        = ROW_W'(1);
                    state_next     = (nrm1 == '0) ? S_BLANK : S_COPY;
                end

                if (cmd_reg.command != tcce_pkg::CMD_READ_CELL)
                begin
                    done_next                  = 1'b1;
                    result_next.cursor_row     = nrow;
                    result_next.cursor_column  = ncol;
                    result_next.cursor_shown   = nvis;
                    result_next.scrolled       = sc ||
                                                 (cmd_reg.command == tcce_pkg::CMD_CLEAR);
                    result_next.cell_changed   = chg;
                    result_next.cell_row       = cr;
                    result_next.cell_column    = cc;
                    result_next.cell_char      = cch;
                    result_next.cell_attribute = cat;
                end
            end

            S_READ:
            begin
                // Present the stored cell, zero outside the store
                done_next                  = 1'b1;
                result_next.cursor_row     = cur_row_reg;
                result_next.cursor_column  = cur_col_reg;
                result_next.cursor_shown   = vis_reg;
                result_next.scrolled       = 1'b0;
                result_next.cell_changed   = 1'b0;
                result_next.cell_row       = cmd_reg.target_row;
                result_next.cell_column    = cmd_reg.target_column;
                result_next.cell_char      = rd_ok_reg ? rd_data[7:0] : '0;
                result_next.cell_attribute = rd_ok_reg ? rd_data[15:8] : '0;
                state_next                 = S_IDLE;
            end

            S_COPY:
            begin
                // Read row y, write it into row y-1 in the next cycle
                rd_en          = 1'b1;
                rd_addr        = cell_addr(sy_reg, sx_reg);
                copy_pend_next = 1'b1;
                pend_addr_next = cell_addr(sy_reg - ROW_W'(1), sx_reg);
                wr_en          = copy_pend_reg;
                wr_addr        = pend_addr_reg;
                wr_data        = rd_data;
                if (sx_reg == last_col_reg)
                begin
                    sx_next = '0;
                    if (sy_reg == last_row_reg)
                    begin
                        state_next = S_BLANK;
                    end
                    else
                    begin
                        sy_next = sy_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    sx_next = sx_reg + COL_W'(1);
                end
            end

            S_BLANK:
            begin
                // Drain the last copy first, then blank the bottom row
                wr_en = 1'b1;
                if (copy_pend_reg)
                begin
                    wr_addr = pend_addr_reg;
                    wr_data = rd_data;
                end
                else
                begin
                    wr_addr = cell_addr(last_row_reg, sx_reg);
                    wr_data = {fill_attr_reg, tcce_pkg::CH_BLANK};
                    if (sx_reg == last_col_reg)
                    begin
                        sx_next    = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sx_next = sx_reg + COL_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            vis_reg       <= 1'b1;
            blink_reg     <= '0;
            sy_reg        <= '0;
            sx_reg        <= '0;
            last_row_reg  <= '0;
            last_col_reg  <= '0;
            fill_attr_reg <= tcce_pkg::RESET_ATTR;
            copy_pend_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            vis_reg       <= vis_next;
            blink_reg     <= blink_next;
            sy_reg        <= sy_next;
            sx_reg        <= sx_next;
            last_row_reg  <= last_row_next;
            last_col_reg  <= last_col_next;
            fill_attr_reg <= fill_attr_next;
            copy_pend_reg <= copy_pend_next;
            rd_ok_reg     <= rd_ok_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_addr_reg <= pend_addr_next;
        result_reg    <= result_next;
    end

endmodule

### design/text_console_cell_engine.sv
// Character-cell console engine. Raise start with a command on request while busy
// is low; the item is taken at that edge. Each item gives exactly one result,
// shown on result for a single cycle with done high; the receiver cannot stall,
// so it must take the result in that cycle. Cursor moves, put_char without a
// scroll, set_cursor, home and blink_tick pass through capture and execute,
// and read_cell then presents the registered read data of the cell memory. A
// scroll keeps busy high afterwards while each visible cell of the upper rows
// is copied once through the single write port and then the bottom row is
// blanked; clear keeps it high while all MAX_ROWS * 2**ceil(log2(MAX_COLUMNS))
// store entries (12288 at the defaults) are blanked, one entry a cycle. After
// reset the same clearing pass runs with attribute 0x07 before the first item is
// taken. Registers are written over the APB port at byte addresses 0, 4 and 8.
module text_console_cell_engine #(
    parameter int MAX_ROWS    = 96,
    parameter int MAX_COLUMNS = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  tcce_pkg::tcce_in_t               request,
    output logic                             busy,
    output logic                             done,
    output tcce_pkg::tcce_out_t              result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcce_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    tcce_pkg::tcce_cfg_t cfg;

    // Configuration registers
    tcce_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Command sequencer with the cell store
    tcce_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .cfg     (cfg),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

endmodule

### design/tcce_checker.sv
module tcce_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input tcce_pkg::tcce_out_t result
);

    // An accepted item makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // Every result follows work done with busy high
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // Results never come in adjacent cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in adjacent cycles");

    // A newline is never reported as a written cell
    a_changed_cell: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.cell_changed |-> result.cell_char != tcce_pkg::CH_NEWLINE)
        else $error("newline reported as written cell");

endmodule

bind text_console_cell_engine tcce_checker u_checker (.*);

### tb/tb.sv
module tb;

    localparam int ROWS = 96;
    localparam int COLS = 128;

    // Track console state, predict each status item and hold it until it arrives
    class console_tracker;
        logic [15:0]          cells [ROWS*COLS];
        int                   row;
        int                   col;
        bit                   shown;
        int                   ticks;
        int                   col_reg;
        int                   row_reg;
        int                   blink_reg;
        tcce_pkg::tcce_out_t  status_due [$];
        int                   mismatches;

        function new();
            fill(tcce_pkg::RESET_ATTR);
            row        = 0;
            col        = 0;
            shown      = 1'b1;
            ticks      = 0;
            col_reg    = int'(tcce_pkg::COLUMNS_RESET);
            row_reg    = int'(tcce_pkg::ROWS_RESET);
            blink_reg  = int'(tcce_pkg::BLINK_RESET);
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                tcce_pkg::REG_COLUMNS: col_reg   = int'(value[7:0]);
                tcce_pkg::REG_ROWS:    row_reg   = int'(value[6:0]);
                tcce_pkg::REG_BLINK:   blink_reg = int'(value[7:0]);
                default:               ;
            endcase
        endfunction

        // Zero acts as one, anything past the store acts as the store size
        function int width_now();
            if (col_reg == 0)
                return 1;
            return (col_reg > COLS) ? COLS : col_reg;
        endfunction

        function int height_now();
            if (row_reg == 0)
                return 1;
            return (row_reg > ROWS) ? ROWS : row_reg;
        endfunction

        function void fill(logic [7:0] attr);
            for (int i = 0; i < ROWS*COLS; i++)
                cells[i] = {attr, tcce_pkg::CH_BLANK};
        endfunction

        // Shift the visible rows up by one and blank the bottom row
        function void scroll(int nr, int nc, logic [7:0] attr);
            for (int y = 1; y < nr; y++)
                for (int x = 0; x < nc; x++)
                    cells[(y-1)*COLS + x] = cells[y*COLS + x];
            for (int x = 0; x < nc; x++)
                cells[(nr-1)*COLS + x] = {attr, tcce_pkg::CH_BLANK};
            row = nr - 1;
        endfunction

        function void take_command(tcce_pkg::tcce_in_t it);
            tcce_pkg::tcce_out_t st;
            int                  nc;
            int                  nr;
            int                  period;
            int                  next_count;
            nc = width_now();
            nr = height_now();
            st = '0;
            // saturate the cursor into the current area
            if (row >= nr)
                row = nr - 1;
            if (col >= nc)
                col = nc - 1;
            case (it.command)
                tcce_pkg::CMD_PUT_CHAR:
                begin
                    if (it.character == tcce_pkg::CH_NEWLINE)
                    begin
                        col = 0;
                        row++;
                        if (row >= nr)
                        begin
                            scroll(nr, nc, it.attribute);
                            st.scrolled = 1'b1;
                        end
                    end
                    else if (it.character == tcce_pkg::CH_RETURN)
                        col = 0;
                    else if (it.character == tcce_pkg::CH_BACKSPACE)
                    begin
                        // nothing to erase at the top-left cell
                        if (col > 0 || row > 0)
                        begin
                            if (col > 0)
                                col--;
                            else
                            begin
                                row--;
                                col = nc - 1;
                            end
                            cells[row*COLS + col] = {it.attribute, tcce_pkg::CH_BLANK};
                            st.cell_changed   = 1'b1;
                            st.cell_row       = 7'(row);
                            st.cell_column    = 7'(col);
                            st.cell_char      = tcce_pkg::CH_BLANK;
                            st.cell_attribute = it.attribute;
                        end
                    end
                    else
                    begin
                        // report the cell as written, before any scroll
                        cells[row*COLS + col] = {it.attribute, it.character};
                        st.cell_changed   = 1'b1;
                        st.cell_row       = 7'(row);
                        st.cell_column    = 7'(col);
                        st.cell_char      = it.character;
                        st.cell_attribute = it.attribute;
                        col++;
                        if (col >= nc)
                        begin
                            col = 0;
                            row++;
                            if (row >= nr)
                            begin
                                scroll(nr, nc, it.attribute);
                                st.scrolled = 1'b1;
                            end
                        end
                    end
                    shown = 1'b1;
                end
                tcce_pkg::CMD_SET_CURSOR:
                begin
                    row   = (int'(it.target_row) >= nr) ? nr - 1 : int'(it.target_row);
                    col   = (int'(it.target_column) >= nc) ? nc - 1 : int'(it.target_column);
                    shown = 1'b1;
                end
                tcce_pkg::CMD_LEFT:
                begin
                    if (col > 0)
                        col--;
                    else if (row > 0)
                    begin
                        row--;
                        col = nc - 1;
                    end
                end
                tcce_pkg::CMD_RIGHT:
                begin
                    if (col + 1 < nc)
                        col++;
                    else if (row + 1 < nr)
                    begin
                        row++;
                        col = 0;
                    end
                end
                tcce_pkg::CMD_HOME:
                    col = 0;
                tcce_pkg::CMD_CLEAR:
                begin
                    fill(it.attribute);
                    row         = 0;
                    col         = 0;
                    shown       = 1'b1;
                    ticks       = 0;
                    st.scrolled = 1'b1;
                end
                tcce_pkg::CMD_BLINK_TICK:
                begin
                    // a count at or past the period toggles, even a stale one
                    period     = (blink_reg == 0) ? 1 : blink_reg;
                    next_count = ticks + 1;
                    if (next_count >= period)
                    begin
                        ticks = 0;
                        shown = !shown;
                    end
                    else
                        ticks = next_count & 255;
                end
                default:
                begin
                    st.cell_row    = it.target_row;
                    st.cell_column = it.target_column;
                    if (int'(it.target_row) < ROWS && int'(it.target_column) < COLS)
                    begin
                        st.cell_char      = cells[int'(it.target_row)*COLS +
                                                  int'(it.target_column)][7:0];
                        st.cell_attribute = cells[int'(it.target_row)*COLS +
                                                  int'(it.target_column)][15:8];
                    end
                end
            endcase
            st.cursor_row    = 7'(row);
            st.cursor_column = 7'(col);
            st.cursor_shown  = shown;
            status_due.push_back(st);
        endfunction

        function void report(string name, int want, int got);
            if (want != got)
            begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void match_status(tcce_pkg::tcce_out_t got);
            tcce_pkg::tcce_out_t want;
            if (status_due.size() == 0)
            begin
                mismatches++;
                $error("status item with no command outstanding");
                return;
            end
            want = status_due.pop_front();
            report("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
            report("cursor_column", int'(want.cursor_column), int'(got.cursor_column));
            report("cursor_shown", int'(want.cursor_shown), int'(got.cursor_shown));
            report("scrolled", int'(want.scrolled), int'(got.scrolled));
            report("cell_changed", int'(want.cell_changed), int'(got.cell_changed));
            report("cell_row", int'(want.cell_row), int'(got.cell_row));
            report("cell_column", int'(want.cell_column), int'(got.cell_column));
            report("cell_char", int'(want.cell_char), int'(got.cell_char));
            report("cell_attribute", int'(want.cell_attribute), int'(got.cell_attribute));
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                start;
    tcce_pkg::tcce_in_t                  request;
    logic                                busy;
    logic                                done;
    tcce_pkg::tcce_out_t                 result;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [tcce_pkg::CFG_ADDR_W-1:0]     paddr;
    logic [31:0]                         pwdata;
    logic [31:0]                         prdata;
    logic                                pready;

    console_tracker                      tracker;
    int                                  calm_left;

    text_console_cell_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Check every status item in the cycle it is shown
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.match_status(result);
    end

    function automatic tcce_pkg::tcce_in_t make_item(tcce_pkg::tcce_cmd_t c,
                                                     logic [7:0] ch, logic [7:0] attr,
                                                     logic [6:0] r, logic [6:0] cl);
        tcce_pkg::tcce_in_t it;
        it.command       = c;
        it.character     = ch;
        it.attribute     = attr;
        it.target_row    = r;
        it.target_column = cl;
        return it;
    endfunction

    function automatic tcce_pkg::tcce_in_t random_item(int nr, int nc);
        tcce_pkg::tcce_in_t it;
        int                 pick;
        it.character = 8'($urandom_range(0, 255));
        it.attribute = 8'($urandom);
        // aim most targets at the visible area, the rest anywhere in the field
        if ($urandom_range(0, 9) < 6)
        begin
            it.target_row    = 7'($urandom_range(0, nr - 1));
            it.target_column = 7'($urandom_range(0, nc - 1));
        end
        else
        begin
            it.target_row    = 7'($urandom);
            it.target_column = 7'($urandom);
        end
        pick = $urandom_range(0, 199);
        if (pick < 90)
        begin
            it.command = tcce_pkg::CMD_PUT_CHAR;
            case ($urandom_range(0, 9))
                0:       it.character = tcce_pkg::CH_NEWLINE;
                1:       it.character = tcce_pkg::CH_RETURN;
                2:       it.character = tcce_pkg::CH_BACKSPACE;
                default: ;
            endcase
        end
        else if (pick < 108)
            it.command = tcce_pkg::CMD_SET_CURSOR;
        else if (pick < 120)
            it.command = tcce_pkg::CMD_LEFT;
        else if (pick < 132)
            it.command = tcce_pkg::CMD_RIGHT;
        else if (pick < 138)
            it.command = tcce_pkg::CMD_HOME;
        else if (pick < 140)
            it.command = tcce_pkg::CMD_CLEAR;
        else if (pick < 165)
            it.command = tcce_pkg::CMD_BLINK_TICK;
        else
            it.command = tcce_pkg::CMD_READ_CELL;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the block takes it
    task automatic send_item(input tcce_pkg::tcce_in_t it);
        int gap;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 15) == 0)
                calm_left = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request <= it;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        tracker.take_command(it);
    endtask

    // Drop start and wait until every status item is back and the block is idle
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.status_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int cols, input int rows, input int period);
        wait_drained();
        write_reg(tcce_pkg::REG_COLUMNS, 32'(cols));
        write_reg(tcce_pkg::REG_ROWS, 32'(rows));
        write_reg(tcce_pkg::REG_BLINK, 32'(period));
    endtask

    task automatic run_directed();
        send_item(make_item(tcce_pkg::CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 7'd0));
        // read outside the store echoes the position
        send_item(make_item(tcce_pkg::CMD_READ_CELL, 8'hFF, 8'hFF, 7'd127, 7'd127));
        // read inside the store but outside the visible area
        send_item(make_item(tcce_pkg::CMD_READ_CELL, 8'h00, 8'h00, 7'd95, 7'd127));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, tcce_pkg::CH_BACKSPACE, 8'h4E,
                            7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_LEFT, 8'h00, 8'h00, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, 8'h41, 8'hFF, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, 8'h00, 8'h00, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, tcce_pkg::CH_BACKSPACE, 8'h1E,
                            7'd0, 7'd0));
        // clamp to the bottom-right visible cell
        send_item(make_item(tcce_pkg::CMD_SET_CURSOR, 8'h00, 8'h00, 7'd127, 7'd127));
        send_item(make_item(tcce_pkg::CMD_RIGHT, 8'h00, 8'h00, 7'd0, 7'd0));
        // write at the last cell, wrap and scroll in one step
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, 8'hFF, 8'h5A, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_READ_CELL, 8'h00, 8'h00, 7'd23, 7'd79));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, tcce_pkg::CH_NEWLINE, 8'h3C,
                            7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, tcce_pkg::CH_RETURN, 8'h00,
                            7'd0, 7'd0));
        // backspace across the row end
        send_item(make_item(tcce_pkg::CMD_SET_CURSOR, 8'h00, 8'h00, 7'd1, 7'd0));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, tcce_pkg::CH_BACKSPACE, 8'h2B,
                            7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_SET_CURSOR, 8'h00, 8'h00, 7'd5, 7'd40));
        send_item(make_item(tcce_pkg::CMD_HOME, 8'h00, 8'h00, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_SET_CURSOR, 8'h00, 8'h00, 7'd3, 7'd79));
        send_item(make_item(tcce_pkg::CMD_RIGHT, 8'h00, 8'h00, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_LEFT, 8'h00, 8'h00, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_BLINK_TICK, 8'h00, 8'h00, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_CLEAR, 8'h00, 8'hA5, 7'd0, 7'd0));
        send_item(make_item(tcce_pkg::CMD_READ_CELL, 8'h00, 8'h00, 7'd95, 7'd127));
        send_item(make_item(tcce_pkg::CMD_PUT_CHAR, 8'h7E, 8'h80, 7'd0, 7'd0));
    endtask

    // Mix single commands with runs of bytes 32 to 255 that drive wraps and scrolls
    task automatic run_random(input int count);
        int                 sent;
        int                 burst;
        tcce_pkg::tcce_in_t it;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                burst = $urandom_range(4, 20);
                repeat (burst)
                begin
                    it = make_item(tcce_pkg::CMD_PUT_CHAR, 8'($urandom_range(32, 255)),
                                   8'($urandom), 7'($urandom), 7'($urandom));
                    send_item(it);
                    sent++;
                end
            end
            else
            begin
                it = random_item(tracker.height_now(), tracker.width_now());
                send_item(it);
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker   = new();
        calm_left = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random(250);
        // zero registers act as one
        apply_setting(0, 0, 0);
        run_random(200);
        // values past the store size act as the store size
        apply_setting(255, 127, 255);
        run_random(150);
        // shrink with the cursor and blink count left beyond the new limits
        apply_setting(8, 4, 3);
        run_random(400);
        apply_setting(128, 1, 1);
        run_random(150);
        apply_setting(1, 96, 2);
        run_random(150);
        apply_setting(37, 13, 7);
        run_random(300);

        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.status_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
